// ===== src/ast_pkg.sv =====
`default_nettype none

package ast_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_ZERO,
      MODE_NUM,
      MODE_COMMENT
   } scan_mode_type;

   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_TOKEN = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [5:0] TOK_NONE     = 6'd0;
   localparam logic [5:0] TOK_COMMA    = 6'd0;
   localparam logic [5:0] TOK_NEWLINE  = 6'd1;
   localparam logic [5:0] TOK_COMMENT  = 6'd2;
   localparam logic [5:0] TOK_IDENT    = 6'd3;
   localparam logic [5:0] TOK_LABEL    = 6'd4;
   localparam logic [5:0] TOK_NUMBER   = 6'd5;
   localparam logic [5:0] TOK_KW_BASE  = 6'd6;
   localparam logic [5:0] TOK_REG_BASE = 6'd24;
   localparam logic [5:0] TOK_ERROR    = 6'd40;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_US    = 8'h5F;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_X     = 8'h78;

   localparam logic [62:0] NUM_MAX = {63{1'b1}};

   // Suffix codes for register names: 0..7 value so far, then these two.
   localparam logic [3:0] SUFFIX_BIG = 4'd8;
   localparam logic [3:0] SUFFIX_BAD = 4'd15;

   // Keyword text, first character in the top byte, zero padded.
   localparam int KW_COUNT = 18;
   localparam logic [47:0] KW_TEXT [0:KW_COUNT-1] = '{
      {"mov", 24'h0}, {"hlt", 24'h0}, {"sp", 32'h0}, {"srr", 24'h0},
      {"srw", 24'h0}, {"stb", 24'h0}, {"stw", 24'h0}, {"stl", 24'h0},
      {"stq", 24'h0}, {"or", 32'h0}, {"litr", 16'h0}, {"ldb", 24'h0},
      {"ldw", 24'h0}, {"ldl", 24'h0}, {"ldq", 24'h0}, {".byte", 8'h0},
      {".skip", 8'h0}, {"b", 40'h0}
   };

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  token_type;
      logic [62:0] number_value;
      logic [7:0]  text_byte;
      logic [31:0] line_number;
      logic        last;
   } result_type;

   function automatic result_type make_result(input logic [1:0] kind,
                                              input logic [5:0] tt,
                                              input logic [62:0] val,
                                              input logic [7:0] text,
                                              input logic [31:0] line);
      result_type r;
      r.kind         = kind;
      r.token_type   = tt;
      r.number_value = val;
      r.text_byte    = text;
      r.line_number  = line;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/assembly_source_tokenizer_unit.sv =====
// Assembly source tokenizer.
// The req_ channel takes one source byte per transfer in req_tdata, or an
// end-of-input mark when req_tuser is high (the byte is then ignored).
// The rsp_ channel sends the token stream: echoed identifier bytes, finished
// tokens and an end-of-stream item, with rsp_tlast on the last result that
// an input transfer causes. An input transfer causes zero, one or two results.
// Results are computed in the cycle of the input transfer and written into a
// three-entry result queue whose head entry drives the rsp_ channel; a second
// result waits in the queue behind the first.
// Throughput is one input byte per cycle while each byte gives at most one
// result and the receiver keeps up; a byte that gives two results leaves one
// more in the queue, since the single result port sends one at a time.
// When the receiver stalls, the queue fills and req_tready drops once it
// holds two or more results; nothing is lost.
// Reset clears the queue, puts the scanner between tokens and sets the line
// count to one. An end-of-input mark finishes any pending identifier or
// number, sends the end-of-stream item and returns all scanner state,
// line count included, to its reset values.
`default_nettype none

module assembly_source_tokenizer_unit
   import ast_pkg::*;
#(
   parameter int MAX_NUMBER_DIGITS = 23,
   parameter int KEYWORD_CHARS     = 5
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] source_byte
   input  wire logic         req_tuser,   // [0] end_of_input
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,   // [62:0] number_value, [70:63] text_byte,
                                          // [102:71] line_number, [103] zero
   output logic [7:0]        rsp_tuser,   // [1:0] kind, [7:2] token_type
   output logic              rsp_tlast
);

   localparam int LEN_W  = $clog2(KEYWORD_CHARS + 2);
   localparam int DC_W   = $clog2(MAX_NUMBER_DIGITS + 1);
   localparam int HAVE_N = (KEYWORD_CHARS < 6) ? KEYWORD_CHARS : 6;

   scan_mode_type                   mode_ff, mode_in;
   logic [KEYWORD_CHARS-1:0][7:0]   kc_ff, kc_in;
   logic [LEN_W-1:0]                len_ff, len_in;
   logic [3:0]                      suf_ff, suf_in;
   logic [62:0]                     acc_ff, acc_in;
   logic [DC_W-1:0]                 count_ff, count_in;
   logic                            hex_ff, hex_in;
   logic [31:0]                     line_ff, line_in;

   result_type                      q_ff [0:2];
   result_type                      q_in [0:2];
   logic [1:0]                      qcnt_ff, qcnt_in;

   logic [7:0]  c;
   logic        accept, pop;
   logic        is_alpha, is_dec, is_hexl, is_ident_char, is_ws;
   logic [3:0]  digit_val;
   logic        digit_ok;
   logic [66:0] num_prod, num_sum;
   logic [62:0] acc_next;
   logic [DC_W-1:0] count_inc;
   logic [31:0] line_inc;
   logic [5:0]  ident_tt;
   logic [47:0] have;
   logic        kw_found;
   logic        is_reg;

   logic        emit_a, emit_b, rescan;
   result_type  res_a, res_b, r0, r1;
   logic [1:0]  n_res;
   logic [1:0]  cnt_after;

   assign c      = req_tdata;
   assign accept = req_tvalid & req_tready;
   assign pop    = rsp_tvalid & rsp_tready;

   // Character classes and digit arithmetic.
   always_comb begin
      is_alpha      = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
      is_dec        = (c >= CH_ZERO && c <= 8'h39);
      is_hexl       = (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
      is_ident_char = is_alpha || is_dec || (c == CH_US);
      is_ws         = (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB) ||
                      (c == CH_FF) || (c == CH_NUL);
      digit_val     = is_dec ? c[3:0] : c[3:0] + 4'd9;
      digit_ok      = hex_ff ? (is_dec || is_hexl) : is_dec;
      num_prod      = hex_ff ? {acc_ff, 4'b0000}
                             : ({1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0});
      num_sum       = num_prod + {63'd0, digit_val};
      // The sum passes 2^63-1 exactly when the value has to saturate.
      acc_next      = (|num_sum[66:63]) ? NUM_MAX : num_sum[62:0];
      count_inc     = count_ff + DC_W'(1);
      line_inc      = line_ff + 32'd1;
   end

   // Type of a finished identifier.
   always_comb begin
      have     = '0;
      kw_found = 1'b0;
      ident_tt = TOK_IDENT;
      for (int i = 0; i < HAVE_N; i++) begin
         have[47-8*i -: 8] = kc_ff[i];
      end
      is_reg = ((kc_ff[0] == CH_A) || (kc_ff[0] == CH_G)) &&
               (len_ff >= LEN_W'(2)) && (suf_ff <= 4'd7);
      if (is_reg) begin
         ident_tt = TOK_REG_BASE + {2'b00, (kc_ff[0] == CH_G), suf_ff[2:0]};
      end else if (len_ff <= LEN_W'(KEYWORD_CHARS)) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (!kw_found && have == KW_TEXT[k]) begin
               kw_found = 1'b1;
               ident_tt = TOK_KW_BASE + 6'(k);
            end
         end
      end
   end

   // Scanner next state and results.
   always_comb begin
      mode_in  = mode_ff;
      kc_in    = kc_ff;
      len_in   = len_ff;
      suf_in   = suf_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      hex_in   = hex_ff;
      line_in  = line_ff;
      emit_a   = 1'b0;
      emit_b   = 1'b0;
      rescan   = 1'b0;
      res_a    = '0;
      res_b    = '0;

      if (req_tuser) begin
         if (mode_ff == MODE_IDENT) begin
            emit_a = 1'b1;
            res_a  = make_result(KIND_TOKEN, ident_tt, '0, '0, line_ff);
         end else if (mode_ff == MODE_NUM || mode_ff == MODE_ZERO) begin
            emit_a = 1'b1;
            res_a  = make_result(KIND_TOKEN, TOK_NUMBER, acc_ff, '0, line_ff);
         end
         emit_b   = 1'b1;
         res_b    = make_result(KIND_END, TOK_NONE, '0, '0, line_ff);
         mode_in  = MODE_IDLE;
         kc_in    = '0;
         len_in   = '0;
         suf_in   = '0;
         acc_in   = '0;
         count_in = '0;
         hex_in   = 1'b0;
         line_in  = 32'd1;
      end else begin
         unique case (mode_ff) inside
            MODE_COMMENT: begin
               if (c == CH_NL) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDENT: begin
               if (is_ident_char) begin
                  emit_a = 1'b1;
                  res_a  = make_result(KIND_TEXT, TOK_IDENT, '0, c, line_ff);
                  for (int i = 0; i < KEYWORD_CHARS; i++) begin
                     if (len_ff == LEN_W'(i)) begin
                        kc_in[i] = c;
                     end
                  end
                  if (len_ff < LEN_W'(KEYWORD_CHARS + 1)) begin
                     len_in = len_ff + LEN_W'(1);
                  end
                  if (suf_ff != SUFFIX_BAD) begin
                     if (!is_dec) begin
                        suf_in = SUFFIX_BAD;
                     end else if (suf_ff == 4'd0) begin
                        suf_in = (c[3:0] > 4'd7) ? SUFFIX_BIG : c[3:0];
                     end else if (suf_ff <= 4'd7) begin
                        suf_in = SUFFIX_BIG;
                     end
                  end
               end else if (c == CH_COLON) begin
                  emit_a  = 1'b1;
                  res_a   = make_result(KIND_TOKEN, TOK_LABEL, '0, '0, line_ff);
                  mode_in = MODE_IDLE;
               end else begin
                  emit_a = 1'b1;
                  res_a  = make_result(KIND_TOKEN, ident_tt, '0, '0, line_ff);
                  rescan = 1'b1;
               end
            end
            MODE_ZERO, MODE_NUM: begin
               mode_in = MODE_NUM;
               if (mode_ff == MODE_ZERO && c == CH_X) begin
                  hex_in = 1'b1;
               end else if (c == CH_US) begin
                  // Separators inside a number are skipped.
               end else if (digit_ok) begin
                  acc_in   = acc_next;
                  count_in = count_inc;
                  if (count_inc >= DC_W'(MAX_NUMBER_DIGITS)) begin
                     emit_a  = 1'b1;
                     res_a   = make_result(KIND_TOKEN, TOK_NUMBER, acc_next, '0, line_ff);
                     mode_in = MODE_IDLE;
                  end
               end else begin
                  emit_a = 1'b1;
                  res_a  = make_result(KIND_TOKEN, TOK_NUMBER, acc_ff, '0, line_ff);
                  rescan = 1'b1;
               end
            end
            default: begin
               rescan = 1'b1;
            end
         endcase

         // Scans a byte between tokens or one that ends an identifier or number.
         if (rescan) begin
            mode_in = MODE_IDLE;
            if (is_ws) begin
               mode_in = MODE_IDLE;
            end else if (c == CH_COMMA) begin
               emit_b = 1'b1;
               res_b  = make_result(KIND_TOKEN, TOK_COMMA, '0, '0, line_ff);
            end else if (c == CH_NL) begin
               line_in = line_inc;
               emit_b  = 1'b1;
               res_b   = make_result(KIND_TOKEN, TOK_NEWLINE, '0, '0, line_inc);
            end else if (c == CH_SEMI) begin
               emit_b  = 1'b1;
               res_b   = make_result(KIND_TOKEN, TOK_COMMENT, '0, '0, line_ff);
               mode_in = MODE_COMMENT;
            end else if (is_alpha || c == CH_US || c == CH_DOT) begin
               kc_in    = '0;
               kc_in[0] = c;
               len_in   = LEN_W'(1);
               suf_in   = '0;
               mode_in  = MODE_IDENT;
               emit_b   = 1'b1;
               res_b    = make_result(KIND_TEXT, TOK_IDENT, '0, c, line_ff);
            end else if (is_dec) begin
               hex_in = 1'b0;
               if (c == CH_ZERO) begin
                  acc_in   = '0;
                  count_in = '0;
                  mode_in  = MODE_ZERO;
               end else begin
                  acc_in   = {59'd0, c[3:0]};
                  count_in = DC_W'(1);
                  mode_in  = MODE_NUM;
                  if (MAX_NUMBER_DIGITS <= 1) begin
                     emit_b  = 1'b1;
                     res_b   = make_result(KIND_TOKEN, TOK_NUMBER, {59'd0, c[3:0]}, '0,
                                           line_ff);
                     mode_in = MODE_IDLE;
                  end
               end
            end else begin
               emit_b = 1'b1;
               res_b  = make_result(KIND_TOKEN, TOK_ERROR, '0, c, line_ff);
            end
         end
      end

      r0      = emit_a ? res_a : res_b;
      r0.last = !(emit_a && emit_b);
      r1      = res_b;
      r1.last = 1'b1;
      n_res   = accept ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
   end

   // Result queue: entry zero is the one offered on the rsp_ channel.
   always_comb begin
      cnt_after = qcnt_ff - {1'b0, pop};
      q_in[0]   = pop ? q_ff[1] : q_ff[0];
      q_in[1]   = pop ? q_ff[2] : q_ff[1];
      q_in[2]   = q_ff[2];
      for (int j = 0; j < 3; j++) begin
         if (n_res != 2'd0 && {1'b0, cnt_after} == 3'(j)) begin
            q_in[j] = r0;
         end
         if (n_res == 2'd2 && ({1'b0, cnt_after} + 3'd1) == 3'(j)) begin
            q_in[j] = r1;
         end
      end
      qcnt_in = cnt_after + n_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         kc_ff    <= '0;
         len_ff   <= '0;
         suf_ff   <= '0;
         acc_ff   <= '0;
         count_ff <= '0;
         hex_ff   <= 1'b0;
         line_ff  <= 32'd1;
         qcnt_ff  <= 2'd0;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            kc_ff    <= kc_in;
            len_ff   <= len_in;
            suf_ff   <= suf_in;
            acc_ff   <= acc_in;
            count_ff <= count_in;
            hex_ff   <= hex_in;
            line_ff  <= line_in;
         end
         qcnt_ff <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         q_ff[j] <= q_in[j];
      end
   end

   assign req_tready = (qcnt_ff <= 2'd1);
   assign rsp_tvalid = (qcnt_ff != 2'd0);
   assign rsp_tdata  = {1'b0, q_ff[0].line_number, q_ff[0].text_byte, q_ff[0].number_value};
   assign rsp_tuser  = {q_ff[0].token_type, q_ff[0].kind};
   assign rsp_tlast  = q_ff[0].last;

   // A two-result transfer must always find two free queue entries.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (accept && n_res == 2'd2) |-> (cnt_after <= 2'd1))
      else $error("result queue overflow");

   // The end-of-stream item always closes the results of its transfer.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && q_ff[0].kind == KIND_END) |-> q_ff[0].last)
      else $error("end-of-stream result without tlast");

   // A number reaching the digit limit must already have been finished.
   a_digit_limit: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_NUM) |-> (count_ff < DC_W'(MAX_NUMBER_DIGITS)))
      else $error("digit count past limit while scanning a number");

   // An end-of-input transfer restores the line count.
   a_eoi_line: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser) |=> (line_ff == 32'd1 && mode_ff == MODE_IDLE))
      else $error("scanner not restored after end of input");

   // Without new results, a transfer out shrinks the queue by one.
   a_queue_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && n_res == 2'd0) |=> (qcnt_ff == $past(qcnt_ff) - 2'd1))
      else $error("result queue count mismatch");

endmodule

`default_nettype wire
